// ===== hw/rtl/windowed_send_rate_limiter_defines.svh =====
// ---------------------------------------------------------------------------
// Windowed send-rate limiter assertion macros
// Shared assertion forms for the rate limiter's port checker.
// ---------------------------------------------------------------------------
`ifndef WINDOWED_SEND_RATE_LIMITER_DEFINES_SVH
`define WINDOWED_SEND_RATE_LIMITER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSRL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rate limiter property violated");

// Consequent must hold in the cycle after the antecedent.
`define WSRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rate limiter property violated");

`endif

// ===== hw/rtl/wsrl_pkg.sv =====
// ---------------------------------------------------------------------------
// Windowed send-rate limiter package
// Field widths, codes and state encoding shared by the limiter's files.
// ---------------------------------------------------------------------------
package wsrl_pkg;

   localparam int RATE_W    = 24;
   localparam int DIVF_W    = 5;
   localparam int SIZE_W    = 16;
   localparam int TIME_W    = 32;
   localparam int GAP_W     = 26;
   localparam int TOTAL_W   = 23;
   localparam int DROP_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int MPLIER_W  = 10;
   localparam int MUL_CNT_W = 4;

   localparam logic [TOTAL_W-1:0]   TOTAL_MAX  = '1;
   localparam logic [MPLIER_W-1:0]  MS_PER_SEC = 10'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVER_DIV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIENT_DIV = 2'd2;

   typedef enum logic [1:0] {
      ACT_CHECK   = 2'd0,
      ACT_SEND    = 2'd1,
      ACT_GATE    = 2'd2,
      ACT_ADVANCE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/wsrl_serdiv.sv =====
// ---------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; done pulses after the last bit.
// ---------------------------------------------------------------------------
module wsrl_serdiv #(
   parameter int DIVIDEND_W = 26,
   parameter int DIVISOR_W  = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVISOR_W-1:0]  div_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  done_ff;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // The partial remainder stays below the divisor, so the difference
   // always fits back into the remainder register.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNT_W'(1));
         if (start) begin
            cnt_ff <= CNT_W'(DIVIDEND_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/windowed_send_rate_limiter.sv =====
// ---------------------------------------------------------------------------
// Windowed send-rate limiter
// Per-connection bandwidth limiter over a ring of recent frame sizes.
// ---------------------------------------------------------------------------
// Usage: an item is taken at a clock edge where start is high and busy is
// low; req_action selects check, record send, gate query or advance. Each
// item yields exactly one result, shown on the rsp_ ports for one cycle
// while rsp_valid is high. The receiver cannot stall, so nothing waits.
// Configuration registers (rate, server divisor, client divisor) are
// written through the csr_ channel, which is always ready; they should be
// written only while busy is low.
// Steps from the accepting edge to the edge that raises rsp_valid:
//   check with a nonzero rate: the slot-by-slot summing pass, the
//     ten-step shift-add multiplier, the one-bit-per-cycle divider,
//     then the commit state;
//   record send with a nonzero rate: the multiplier, the divider,
//     then the commit state;
//   everything else: the commit state alone.
// One item is in work at a time; busy is low again in the cycle of the
// result strobe, so the next item may be taken at the edge that ends it.
// Reset (synchronous, active high) clears the window, the slot index, the
// send time, the gap, the drop counter, and sets the rate to zero (no
// limiting) and both divisors to one.
// ---------------------------------------------------------------------------
module windowed_send_rate_limiter #(
   parameter int WINDOW_FRAMES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_action,
   input  logic [wsrl_pkg::SIZE_W-1:0]      req_packet_size,
   input  logic [wsrl_pkg::TIME_W-1:0]      req_now_ms,
   input  logic                             req_is_spawned,
   output logic                             rsp_valid,
   output logic                             rsp_suppressed,
   output logic [wsrl_pkg::TOTAL_W-1:0]     rsp_window_total,
   output logic                             rsp_may_send,
   output logic [wsrl_pkg::GAP_W-1:0]       rsp_delay_ms,
   output logic [wsrl_pkg::DROP_W-1:0]      rsp_drop_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wsrl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wsrl_pkg::RATE_W-1:0]      csr_wdata
);

   import wsrl_pkg::*;

   // The window sum needs room for WINDOW_FRAMES full-size packets; the
   // divider dividend must hold both the scaled sum and size * 1000.
   localparam int SLOT_W = $clog2(WINDOW_FRAMES);
   localparam int SUM_W  = SIZE_W + SLOT_W;
   localparam int PROD_W = SUM_W + DIVF_W;
   localparam int QUO_W  = (PROD_W > GAP_W) ? PROD_W : GAP_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_FRAMES - 1);

   // Control state.
   state_type            state_ff, state_in;
   logic [RATE_W-1:0]    rate_ff;
   logic [DIVF_W-1:0]    sdiv_ff;
   logic [DIVF_W-1:0]    cdiv_ff;
   logic [SIZE_W-1:0]    window_ff [WINDOW_FRAMES];
   logic [SLOT_W-1:0]    slot_ff;
   logic [TIME_W-1:0]    last_send_ff;
   logic [GAP_W-1:0]     gap_ff;
   logic [DROP_W-1:0]    drops_ff;
   logic                 rsp_valid_ff;

   // Captured item and serial datapath.
   action_type           action_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [TIME_W-1:0]    now_ff;
   logic                 spawned_ff;
   logic [SLOT_W-1:0]    sum_idx_ff;
   logic [QUO_W-1:0]     acc_ff;
   logic [QUO_W-1:0]     mcand_ff;
   logic [MPLIER_W-1:0]  mplier_ff;
   logic [MUL_CNT_W-1:0] mul_cnt_ff;

   // Result registers.
   logic                 suppressed_ff;
   logic [TOTAL_W-1:0]   total_ff;
   logic                 may_send_ff;
   logic [GAP_W-1:0]     delay_ff;
   logic [DROP_W-1:0]    drop_count_ff;

   // FSM outputs.
   logic                 accept;
   logic                 div_start;
   logic                 finish;

   // Datapath.
   action_type           req_act;
   logic                 rate_on;
   logic [QUO_W-1:0]     sum_next;
   logic [QUO_W-1:0]     mul_next;
   logic [RATE_W-1:0]    divisor;
   logic                 div_done;
   logic [QUO_W-1:0]     quotient;
   logic                 is_check;
   logic                 suppress;
   logic [TOTAL_W-1:0]   total;
   logic [TIME_W-1:0]    elapsed;
   logic                 may_send;
   logic [GAP_W-1:0]     gap_next;
   logic [DROP_W-1:0]    drops_next;

   assign req_act = action_type'(req_action);
   assign rate_on = (rate_ff != '0);

   // -----------------------------------------------------------------------
   // Sequencer: sum (check), multiply, divide (check, send), commit.
   // -----------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority if (req_act == ACT_CHECK && rate_on) begin
                  state_in = ST_SUM;
               end else if (req_act == ACT_SEND && rate_on) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SUM: begin
            if (sum_idx_ff == LAST_SLOT) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_cnt_ff == MUL_CNT_W'(1)) begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = (state_ff != ST_IDLE);
      accept    = start && (state_ff == ST_IDLE);
      div_start = (state_ff == ST_DIV_GO);
      finish    = (state_ff == ST_FINISH);
   end

   // -----------------------------------------------------------------------
   // Serial arithmetic. The sum walks the ring one slot per cycle; the
   // multiplier takes one multiplier bit per cycle, LSB first.
   // -----------------------------------------------------------------------
   assign sum_next = acc_ff + QUO_W'(window_ff[sum_idx_ff]);
   assign mul_next = mplier_ff[0] ? (acc_ff + mcand_ff) : acc_ff;

   // A client divisor of zero behaves as one.
   always_comb begin
      if (action_ff == ACT_CHECK) begin
         divisor = (cdiv_ff == '0) ? RATE_W'(1) : RATE_W'(cdiv_ff);
      end else begin
         divisor = rate_ff;
      end
   end

   wsrl_serdiv #(
      .DIVIDEND_W (QUO_W),
      .DIVISOR_W  (RATE_W)
   ) u_serdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // -----------------------------------------------------------------------
   // Result of the item, evaluated in the commit cycle.
   // -----------------------------------------------------------------------
   always_comb begin
      is_check = (action_ff == ACT_CHECK) && rate_on;
      suppress = is_check && (quotient > QUO_W'(rate_ff));
      if (!is_check) begin
         total = '0;
      end else if (quotient > QUO_W'(TOTAL_MAX)) begin
         total = TOTAL_MAX;
      end else begin
         total = quotient[TOTAL_W-1:0];
      end
      // Wrapping difference, so a timer rollover still compares correctly.
      elapsed  = now_ff - last_send_ff;
      may_send = (action_ff == ACT_GATE) && (elapsed >= TIME_W'(gap_ff));
      if (action_ff == ACT_SEND) begin
         gap_next = rate_on ? quotient[GAP_W-1:0] : '0;
      end else begin
         gap_next = gap_ff;
      end
      drops_next = suppress ? (drops_ff + DROP_W'(1)) : drops_ff;
   end

   // -----------------------------------------------------------------------
   // Control and architectural state.
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= '0;
         sdiv_ff      <= DIVF_W'(1);
         cdiv_ff      <= DIVF_W'(1);
         slot_ff      <= '0;
         last_send_ff <= '0;
         gap_ff       <= '0;
         drops_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_FRAMES; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= finish;

         if (csr_valid) begin
            unique case (csr_index)
               CSR_RATE:       rate_ff <= csr_wdata;
               CSR_SERVER_DIV: sdiv_ff <= csr_wdata[DIVF_W-1:0];
               CSR_CLIENT_DIV: cdiv_ff <= csr_wdata[DIVF_W-1:0];
               default: begin
               end
            endcase
         end

         if (finish) begin
            gap_ff   <= gap_next;
            drops_ff <= drops_next;
            if (suppress) begin
               window_ff[slot_ff] <= '0;
            end
            if (action_ff == ACT_SEND) begin
               last_send_ff <= now_ff;
               if (rate_on && spawned_ff) begin
                  window_ff[slot_ff] <= size_ff;
               end
            end
            if (action_ff == ACT_ADVANCE) begin
               slot_ff <= (slot_ff == LAST_SLOT) ? '0 : (slot_ff + SLOT_W'(1));
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Item capture and serial datapath registers.
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff  <= req_act;
         size_ff    <= req_packet_size;
         now_ff     <= req_now_ms;
         spawned_ff <= req_is_spawned;
         sum_idx_ff <= '0;
         acc_ff     <= '0;
         mcand_ff   <= QUO_W'(req_packet_size);
         mplier_ff  <= MS_PER_SEC;
         mul_cnt_ff <= MUL_CNT_W'(MPLIER_W);
      end else if (state_ff == ST_SUM) begin
         sum_idx_ff <= sum_idx_ff + SLOT_W'(1);
         if (sum_idx_ff == LAST_SLOT) begin
            // Hand the finished sum to the multiplier as the multiplicand.
            mcand_ff   <= sum_next;
            acc_ff     <= '0;
            mplier_ff  <= MPLIER_W'(sdiv_ff);
            mul_cnt_ff <= MUL_CNT_W'(MPLIER_W);
         end else begin
            acc_ff <= sum_next;
         end
      end else if (state_ff == ST_MUL) begin
         acc_ff     <= mul_next;
         mcand_ff   <= {mcand_ff[QUO_W-2:0], 1'b0};
         mplier_ff  <= {1'b0, mplier_ff[MPLIER_W-1:1]};
         mul_cnt_ff <= mul_cnt_ff - MUL_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         suppressed_ff <= suppress;
         total_ff      <= total;
         may_send_ff   <= may_send;
         delay_ff      <= gap_next;
         drop_count_ff <= drops_next;
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_suppressed   = suppressed_ff;
   assign rsp_window_total = total_ff;
   assign rsp_may_send     = may_send_ff;
   assign rsp_delay_ms     = delay_ff;
   assign rsp_drop_count   = drop_count_ff;

endmodule

// ===== hw/rtl/wsrl_checker.sv =====
// ---------------------------------------------------------------------------
// Windowed send-rate limiter port checker
// Watches the limiter's ports and flags results that break its rules.
// ---------------------------------------------------------------------------
`include "windowed_send_rate_limiter_defines.svh"

module wsrl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          rsp_suppressed,
   input logic [wsrl_pkg::TOTAL_W-1:0]  rsp_window_total,
   input logic                          rsp_may_send
);

   // An accepted item always holds busy high in the cycle after it is taken.
   `WSRL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // A result appears only after the block has been working on an item.
   `WSRL_ASSERT_SAME(a_rsp_after_work, clock, reset, rsp_valid, $past(busy))

   // A suppressed frame means the scaled sum exceeded a nonzero rate.
   `WSRL_ASSERT_SAME(a_supp_total, clock, reset, rsp_valid && rsp_suppressed,
      rsp_window_total != '0)

   // Check and gate results never come from the same item.
   `WSRL_ASSERT_SAME(a_supp_gate, clock, reset, rsp_valid && rsp_suppressed,
      !rsp_may_send)

endmodule

bind windowed_send_rate_limiter wsrl_checker u_wsrl_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_suppressed   (rsp_suppressed),
   .rsp_window_total (rsp_window_total),
   .rsp_may_send     (rsp_may_send)
);
